// ===== hw/rtl/servo_shutter_drive_sequencer_top_macros.svh =====
// Assertion macros shared by the drive sequencer RTL.
`ifndef SERVO_SHUTTER_DRIVE_SEQUENCER_TOP_MACROS_SVH
`define SERVO_SHUTTER_DRIVE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SSDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SSDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ssds_pkg.sv =====
// Package with codes, widths and types of the drive sequencer.
package ssds_pkg;

    // Field widths.
    localparam int OP_W       = 3;
    localparam int ARG_W      = 2;
    localparam int DUTY_W     = 11;
    localparam int POS_W      = 2;
    localparam int MODE_W     = 3;
    localparam int PHASE_W    = 2;
    localparam int TIME_W     = 16;
    localparam int COUNT_W    = 17;
    localparam int PULSE_W    = 8;
    localparam int TRIG_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Milliseconds that one tick stands for.
    localparam int TICK_MS = 10;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_STOP     = 3'd1;
    localparam logic [OP_W-1:0] OP_VELOCITY = 3'd2;
    localparam logic [OP_W-1:0] OP_GOTO     = 3'd3;
    localparam logic [OP_W-1:0] OP_SHUTTER  = 3'd4;
    localparam logic [OP_W-1:0] OP_TRIGGER  = 3'd5;

    // Set-shutter argument that opens; every other value closes.
    localparam logic [ARG_W-1:0] ARG_OPEN = 2'd1;

    // Run modes.
    localparam logic [MODE_W-1:0] MODE_STOP       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDLE       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_VEL        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GOTO       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OPEN       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLOSE      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_HOLD_PULSE = 3'd6;
    localparam logic [MODE_W-1:0] MODE_HOLD_VOLT  = 3'd7;

    // Go-to move phases.
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_START = 2'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT  = 2'd2;

    // Positions.
    localparam logic [POS_W-1:0] POS_UNKNOWN = 2'd0;
    localparam logic [POS_W-1:0] POS_ONE     = 2'd1;
    localparam logic [POS_W-1:0] POS_NONE3   = 2'd3;

    // Trigger modes.
    localparam logic [TRIG_W-1:0] TRIG_OFF      = 2'd0;
    localparam logic [TRIG_W-1:0] TRIG_LEVEL    = 2'd1;
    localparam logic [TRIG_W-1:0] TRIG_REVERSED = 2'd2;
    localparam logic [TRIG_W-1:0] TRIG_TOGGLE   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_IS_SHUTTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSIT_TIME_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DUTY         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_DUTY        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DUTY         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSED_ONLY       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE      = 3'd7;

    // Configuration reset values.
    localparam logic [TIME_W-1:0]  RST_TRANSIT_TIME_MS = 16'd2500;
    localparam logic [DUTY_W-1:0]  RST_MOVE_DUTY       = 11'd470;
    localparam logic [PULSE_W-1:0] RST_PULSE_TICKS     = 8'd1;
    localparam logic [DUTY_W-1:0]  RST_PULSE_DUTY      = 11'd1024;
    localparam logic [DUTY_W-1:0]  RST_HOLD_DUTY       = 11'd0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [PULSE_W-1:0] PULSE_MAX = {PULSE_W{1'b1}};

    // One result transaction.
    typedef struct packed {
        logic              drive_enable;
        logic              drive_direction;
        logic [DUTY_W-1:0] duty;
        logic [POS_W-1:0]  current_position;
        logic              shutter_opened;
        logic [MODE_W-1:0] mode_code;
    } t_result;

endpackage

// ===== hw/rtl/ssds_cmd_if.sv =====
// Command and tick channel of the drive sequencer.
interface ssds_cmd_if;
    import ssds_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [ARG_W-1:0] argument;

    modport source (output valid, output operation, output argument, input ready);
    modport sink   (input valid, input operation, input argument, output ready);
endinterface

// ===== hw/rtl/ssds_res_if.sv =====
// Result channel of the drive sequencer.
interface ssds_res_if;
    import ssds_pkg::*;

    logic              valid;
    logic              ready;
    logic              drive_enable;
    logic              drive_direction;
    logic [DUTY_W-1:0] duty;
    logic [POS_W-1:0]  current_position;
    logic              shutter_opened;
    logic [MODE_W-1:0] mode_code;

    modport source (output valid, output drive_enable, output drive_direction, output duty,
                    output current_position, output shutter_opened, output mode_code,
                    input ready);
    modport sink   (input valid, input drive_enable, input drive_direction, input duty,
                    input current_position, input shutter_opened, input mode_code,
                    output ready);
endinterface

// ===== hw/rtl/servo_shutter_drive_sequencer_top.sv =====
// Top level of the servo and solenoid shutter drive sequencer.
//
//  Channel   Direction  Handshake      Contents
//  i_cmd     in         valid/ready    operation, argument
//  o_res     out        valid/ready    drive_enable .. mode_code
//  i_cfg_*   in         write enable   register index, data
//
// The mode update for each i_cmd transaction is combinational logic ahead of the
// state registers, and one result leaves per command.
// The result is held in an output register backed by one skid register, so a
// new command is taken while the previous result still waits on o_res.
// i_cmd.ready drops only while the skid register is full.
// Reset is synchronous and active low; it restores all modes, counters and
// configuration registers to their defaults.

`include "servo_shutter_drive_sequencer_top_macros.svh"

module servo_shutter_drive_sequencer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ssds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ssds_cmd_if.sink                       i_cmd,
    ssds_res_if.source                     o_res
);
    import ssds_pkg::*;

    // Configuration registers.
    logic               r_device_is_shutter;
    logic [TIME_W-1:0]  r_transit_time_ms;
    logic [DUTY_W-1:0]  r_move_duty;
    logic [PULSE_W-1:0] r_pulse_ticks;
    logic [DUTY_W-1:0]  r_pulse_duty;
    logic [DUTY_W-1:0]  r_hold_duty;
    logic               r_pulsed_only;
    logic [TRIG_W-1:0]  r_trigger_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_is_shutter <= 1'b0;
            r_transit_time_ms   <= RST_TRANSIT_TIME_MS;
            r_move_duty         <= RST_MOVE_DUTY;
            r_pulse_ticks       <= RST_PULSE_TICKS;
            r_pulse_duty        <= RST_PULSE_DUTY;
            r_hold_duty         <= RST_HOLD_DUTY;
            r_pulsed_only       <= 1'b1;
            r_trigger_mode      <= TRIG_OFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEVICE_IS_SHUTTER: r_device_is_shutter <= i_cfg_data[0];
                CFG_TRANSIT_TIME_MS:   r_transit_time_ms   <= i_cfg_data[TIME_W-1:0];
                CFG_MOVE_DUTY:         r_move_duty         <= i_cfg_data[DUTY_W-1:0];
                CFG_PULSE_TICKS:       r_pulse_ticks       <= i_cfg_data[PULSE_W-1:0];
                CFG_PULSE_DUTY:        r_pulse_duty        <= i_cfg_data[DUTY_W-1:0];
                CFG_HOLD_DUTY:         r_hold_duty         <= i_cfg_data[DUTY_W-1:0];
                CFG_PULSED_ONLY:       r_pulsed_only       <= i_cfg_data[0];
                CFG_TRIGGER_MODE:      r_trigger_mode      <= i_cfg_data[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state.
    logic [MODE_W-1:0]  r_run_mode,        n_run_mode;
    logic [PHASE_W-1:0] r_move_phase,      n_move_phase;
    logic [POS_W-1:0]   r_target_position, n_target_position;
    logic [POS_W-1:0]   r_stored_position, n_stored_position;
    logic               r_dir,             n_dir;
    logic [COUNT_W-1:0] r_transit_count,   n_transit_count;
    logic [PULSE_W-1:0] r_pulse_count,     n_pulse_count;
    logic               r_shutter_state,   n_shutter_state;
    logic [DUTY_W-1:0]  r_duty,            n_duty;
    logic               r_awake,           n_awake;
    logic               r_bridge_phase,    n_bridge_phase;

    // Output register and skid register.
    t_result r_out, r_skid, w_result;
    logic    r_out_valid, r_skid_valid;

    logic w_in_acc, w_out_pop;
    assign i_cmd.ready = !r_skid_valid;
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;
    assign w_out_pop   = r_out_valid && o_res.ready;

    // The go-to timer advances by one tick of milliseconds and sticks at full scale.
    logic [COUNT_W:0] w_transit_sum;
    logic             w_transit_done;
    assign w_transit_sum  = {1'b0, r_transit_count} + (COUNT_W+1)'(TICK_MS);
    assign w_transit_done = r_transit_count >= {1'b0, r_transit_time_ms};

    always_comb begin
        n_run_mode        = r_run_mode;
        n_move_phase      = r_move_phase;
        n_target_position = r_target_position;
        n_stored_position = r_stored_position;
        n_dir             = r_dir;
        n_transit_count   = r_transit_count;
        n_pulse_count     = r_pulse_count;
        n_shutter_state   = r_shutter_state;
        n_duty            = r_duty;
        n_awake           = r_awake;
        n_bridge_phase    = r_bridge_phase;

        unique case (i_cmd.operation)
            OP_TICK: begin
                unique case (r_run_mode)
                    MODE_STOP: begin
                        n_awake    = 1'b0;
                        n_duty     = '0;
                        n_run_mode = MODE_IDLE;
                    end
                    MODE_VEL: begin
                        n_bridge_phase    = r_dir;
                        n_duty            = r_move_duty;
                        n_awake           = 1'b1;
                        n_stored_position = POS_UNKNOWN;
                    end
                    MODE_GOTO: begin
                        if (r_move_phase == PH_START) begin
                            if (r_target_position == r_stored_position) begin
                                // Already there: let the next tick finish the move.
                                n_transit_count = {1'b0, r_transit_time_ms};
                            end else begin
                                n_dir           = (r_target_position != POS_ONE);
                                n_bridge_phase  = (r_target_position != POS_ONE);
                                n_duty          = r_move_duty;
                                n_awake         = 1'b1;
                                n_transit_count = '0;
                            end
                            n_move_phase = PH_WAIT;
                        end else if (r_move_phase == PH_WAIT) begin
                            if (w_transit_done) begin
                                n_awake           = 1'b0;
                                n_run_mode        = MODE_STOP;
                                n_move_phase      = PH_IDLE;
                                n_stored_position = r_target_position;
                            end
                            n_transit_count = w_transit_sum[COUNT_W] ? COUNT_MAX
                                                                     : w_transit_sum[COUNT_W-1:0];
                        end
                    end
                    MODE_OPEN, MODE_CLOSE: begin
                        // Fire the actuation pulse in the commanded direction.
                        n_shutter_state = (r_run_mode == MODE_OPEN);
                        n_bridge_phase  = (r_run_mode == MODE_OPEN);
                        n_duty          = r_pulse_duty;
                        n_awake         = 1'b1;
                        n_pulse_count   = '0;
                        n_run_mode      = (r_pulse_ticks == PULSE_W'(1)) ? MODE_STOP
                                                                        : MODE_HOLD_PULSE;
                    end
                    MODE_HOLD_PULSE: begin
                        if (r_pulse_count >= r_pulse_ticks) begin
                            if (r_pulsed_only) begin
                                n_run_mode = MODE_STOP;
                            end else begin
                                n_duty     = r_hold_duty;
                                n_run_mode = MODE_HOLD_VOLT;
                            end
                        end
                        if (r_pulse_count != PULSE_MAX) begin
                            n_pulse_count = r_pulse_count + PULSE_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
            OP_STOP: n_run_mode = MODE_STOP;
            OP_VELOCITY: begin
                n_dir      = i_cmd.argument[0];
                n_run_mode = MODE_VEL;
            end
            OP_GOTO: begin
                n_target_position = (i_cmd.argument == POS_NONE3) ? POS_UNKNOWN
                                                                  : i_cmd.argument;
                n_run_mode        = MODE_GOTO;
                n_move_phase      = PH_START;
            end
            OP_SHUTTER: begin
                if (r_device_is_shutter) begin
                    n_shutter_state = (i_cmd.argument == ARG_OPEN);
                    n_run_mode      = (i_cmd.argument == ARG_OPEN) ? MODE_OPEN : MODE_CLOSE;
                end
            end
            OP_TRIGGER: begin
                if (r_device_is_shutter) begin
                    unique case (r_trigger_mode)
                        TRIG_LEVEL:
                            n_run_mode = i_cmd.argument[0] ? MODE_OPEN : MODE_CLOSE;
                        TRIG_REVERSED:
                            n_run_mode = i_cmd.argument[0] ? MODE_CLOSE : MODE_OPEN;
                        TRIG_TOGGLE:
                            n_run_mode = r_shutter_state ? MODE_CLOSE : MODE_OPEN;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // The result reports the drive outputs after this transaction.
    assign w_result.drive_enable     = n_awake;
    assign w_result.drive_direction  = n_bridge_phase;
    assign w_result.duty             = n_duty;
    assign w_result.current_position = n_stored_position;
    assign w_result.shutter_opened   = n_shutter_state;
    assign w_result.mode_code        = n_run_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_mode        <= MODE_STOP;
            r_move_phase      <= PH_IDLE;
            r_target_position <= POS_UNKNOWN;
            r_stored_position <= POS_UNKNOWN;
            r_dir             <= 1'b0;
            r_transit_count   <= '0;
            r_pulse_count     <= '0;
            r_shutter_state   <= 1'b0;
            r_duty            <= '0;
            r_awake           <= 1'b0;
            r_bridge_phase    <= 1'b0;
        end else if (w_in_acc) begin
            r_run_mode        <= n_run_mode;
            r_move_phase      <= n_move_phase;
            r_target_position <= n_target_position;
            r_stored_position <= n_stored_position;
            r_dir             <= n_dir;
            r_transit_count   <= n_transit_count;
            r_pulse_count     <= n_pulse_count;
            r_shutter_state   <= n_shutter_state;
            r_duty            <= n_duty;
            r_awake           <= n_awake;
            r_bridge_phase    <= n_bridge_phase;
        end
    end

    // Output staging. A new transaction goes straight to the output register
    // when it is free or draining; otherwise it parks in the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
                if (r_out_valid && !o_res.ready) begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_out_pop) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (!r_out_valid || o_res.ready) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end else if (w_out_pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.drive_enable     = r_out.drive_enable;
    assign o_res.drive_direction  = r_out.drive_direction;
    assign o_res.duty             = r_out.duty;
    assign o_res.current_position = r_out.current_position;
    assign o_res.shutter_opened   = r_out.shutter_opened;
    assign o_res.mode_code        = r_out.mode_code;

    // A parked result always sits behind a shown one.
    `SSDS_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
                     "skid without output")
    // A parked result stays while the output is stalled.
    `SSDS_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && !o_res.ready,
                      r_skid_valid && r_out_valid, "skid lost under stall")
    // Only a tick can change the recorded position.
    `SSDS_ASSERT_NEXT(a_pos_on_tick, i_clk, i_rst_n,
                      !(w_in_acc && i_cmd.operation == OP_TICK),
                      r_stored_position == $past(r_stored_position),
                      "position moved without tick")
    // The hold modes are entered only from a fired pulse, so the driver is awake.
    `SSDS_ASSERT_NOW(a_hold_awake, i_clk, i_rst_n,
                     r_run_mode == MODE_HOLD_PULSE || r_run_mode == MODE_HOLD_VOLT,
                     r_awake, "hold mode while asleep")

endmodule
